>>> rtl/core/iso_pkg.sv
// Shared types, character codes and constants for the ISO 8601 timestamp parser.
// No dependencies; the top level, the front end and the back end refer to this package.
package iso_pkg;

  // Parse phases of the character front end.
  typedef enum logic [4:0] {
    PH_START      = 5'd0,
    PH_YEAR       = 5'd1,
    PH_MONTH      = 5'd2,
    PH_DAY        = 5'd3,
    PH_AFTER_DATE = 5'd4,
    PH_HOUR       = 5'd5,
    PH_MIN        = 5'd6,
    PH_AFTER_MIN  = 5'd7,
    PH_SEC        = 5'd8,
    PH_AFTER_SEC  = 5'd9,
    PH_DOT        = 5'd10,
    PH_FRAC       = 5'd11,
    PH_PRE_ZONE   = 5'd12,
    PH_ZHOUR      = 5'd13,
    PH_ZCOLON     = 5'd14,
    PH_ZMIN       = 5'd15,
    PH_TRAIL      = 5'd16
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UPT   = 8'h54;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;

  // Months with 31 days, one bit per month number.
  localparam logic [15:0] LONG_MONTH_MASK = 16'h15AA;

  // Half a day plus the Julian date of the Unix epoch, in ms.
  localparam logic signed [51:0] EPOCH_BIAS_MS = 52'sd210866803200000;
  localparam logic signed [51:0] MS_PER_DAY    = 52'sd86400000;

  // Queue depths and the length of the arithmetic pipeline.
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int PIPE_STAGES = 5;

  // One parsed timestamp handed from the front end to the arithmetic.
  typedef struct packed {
    logic        ok;
    logic        year_neg;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  frac_ms;
    logic        zone_given;
    logic        zone_neg;
    logic [3:0]  zone_hour;
    logic [5:0]  zone_minute;
  } rec_t;

  // One finished result.
  typedef struct packed {
    logic        valid;
    logic [49:0] epoch;
  } res_t;

  // Month term of the Julian day formula for adjusted months 3..14.
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/iso8601_timestamp_parser_top.sv
// Top level of the ISO 8601 timestamp parser: front end, record queue,
// arithmetic back end, result queue and the local offset register. Uses iso_pkg.
// Throughput: one character per cycle while the record queue has room; the
// input stalls only when results back up through the result queue.
// From the last character to a result at the output, a record passes the record
// queue, five arithmetic stages and the result queue.
// Reset: synchronous, clears the parse state, both queues and the offset register.
module iso8601_timestamp_parser_top #(
  parameter int MID_DEPTH = iso_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = iso_pkg::OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output logic                empty,
  input  logic                pop,
  output logic signed [49:0]  epoch_ms,
  output logic                valid_res,
  input  logic                cfg_wr_en,
  input  logic signed [11:0]  cfg_wr_data
);

  localparam int REC_W = $bits(iso_pkg::rec_t);
  localparam int RES_W = $bits(iso_pkg::res_t);

  logic signed [11:0]             local_offset_minutes;
  logic                           take;
  logic                           rec_push;
  iso_pkg::rec_t                  rec_in;
  logic [REC_W-1:0]               mid_rdata;
  logic                           mid_empty;
  logic                           rec_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  iso_pkg::res_t                  res;
  logic                           res_push;
  logic [RES_W-1:0]               out_rdata;
  logic                           out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  iso_pkg::res_t                  res_out;

  // Offset register for texts without a zone.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_offset_minutes <= '0;
    end else if (cfg_wr_en) begin
      local_offset_minutes <= cfg_wr_data;
    end
  end

  // A byte is taken whenever the record queue can hold a finished record.
  assign take = push && !full;

  iso_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .last_char (last_char),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  iso_fifo #(.WIDTH(REC_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (REC_W'(rec_in)),
    .pop   (rec_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .full  (full),
    .count (mid_count)
  );

  iso_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .rec_valid            (!mid_empty),
    .rec                  (iso_pkg::rec_t'(mid_rdata)),
    .rec_pop              (rec_pop),
    .local_offset_minutes (local_offset_minutes),
    .out_count            (out_count),
    .res_push             (res_push),
    .res                  (res)
  );

  iso_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (RES_W'(res)),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  // Result ports.
  assign res_out   = iso_pkg::res_t'(out_rdata);
  assign epoch_ms  = $signed(res_out.epoch);
  assign valid_res = res_out.valid;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) res_push |-> !out_full)
    else $error("result written into a full queue");
  a_mid_bound: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> (mid_count < $bits(mid_count)'(MID_DEPTH)))
    else $error("record written into a full queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst) full |-> !take)
    else $error("item taken while the record queue is full");
`endif

endmodule

>>> rtl/core/iso_fifo.sv
// Small synchronous queue used between the parser stages and at the output.
// Depends on nothing; width and depth come from the instantiating module.
module iso_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             empty,
  output logic                             full,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> !empty)
    else $error("queue empty after a write");
  a_last_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == CW'(1)) |=> empty)
    else $error("queue not empty after last read");
`endif

endmodule

>>> rtl/core/iso_front.sv
// Character front end: parses the text one byte per cycle while take is high and emits a record.
// Depends on iso_pkg for phases, character codes and the record type.
module iso_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  output logic               rec_push,
  output iso_pkg::rec_t      rec
);

  typedef struct packed {
    iso_pkg::phase_t phase;
    logic [2:0]      dcnt;
    logic            yneg;
    logic [13:0]     year;
    logic [6:0]      yhi;
    logic [6:0]      ylo;
    logic [6:0]      month;
    logic [6:0]      day;
    logic [6:0]      hour;
    logic [6:0]      minute;
    logic [6:0]      second;
    logic [9:0]      fms;
    logic [2:0]      fd;
    logic            zneg;
    logic [6:0]      zhour;
    logic [6:0]      zmin;
    logic            zgiven;
    logic            err;
  } pst_t;

  pst_t       st;
  pst_t       st_next;
  logic       isd;
  logic [3:0] dig;
  logic       isspc;
  logic       leap;
  logic       dok;
  logic       end_ok;

  function automatic logic [6:0] acc10(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] w;
    w = {4'b0, a} * 11'd10 + {7'b0, d};
    return w[6:0];
  endfunction

  function automatic logic spc(input logic [7:0] c);
    return (c == iso_pkg::CH_SPACE) || (c >= iso_pkg::CH_TAB && c <= iso_pkg::CH_CR);
  endfunction

  // A byte where a zone, white space or the end may follow.
  function automatic pst_t zone_start(input pst_t s, input logic [7:0] c);
    pst_t r;
    r = s;
    if (spc(c)) begin
      r.phase = iso_pkg::PH_PRE_ZONE;
    end else if (c == iso_pkg::CH_PLUS || c == iso_pkg::CH_MINUS) begin
      r.zneg  = (c == iso_pkg::CH_MINUS);
      r.phase = iso_pkg::PH_ZHOUR;
      r.dcnt  = '0;
      r.zhour = '0;
    end else if (c == iso_pkg::CH_UPZ || c == iso_pkg::CH_LOWZ) begin
      r.zgiven = 1'b1;
      r.phase  = iso_pkg::PH_TRAIL;
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  // Character classes.
  assign isd   = (char_code >= iso_pkg::CH_ZERO) && (char_code <= iso_pkg::CH_NINE);
  assign dig   = 4'(char_code - iso_pkg::CH_ZERO);
  assign isspc = spc(char_code);

  // Gregorian leap year from the two digit pairs of the year.
  assign leap = (st.ylo[1:0] == 2'b00) && !((st.ylo == '0) && (st.yhi[1:0] != 2'b00));

  // Next parse state for the byte on the input.
  always_comb begin
    st_next = st;
    dok     = 1'b1;
    if (!st.err) begin
      unique case (st.phase)
        iso_pkg::PH_START: begin
          if (char_code == iso_pkg::CH_MINUS && !st.yneg) begin
            st_next.yneg = 1'b1;
          end else begin
            st_next.phase = iso_pkg::PH_YEAR;
            st_next.dcnt  = '0;
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.year = {10'b0, dig};
              st_next.yhi  = {3'b0, dig};
              st_next.dcnt = 3'd1;
            end
          end
        end
        iso_pkg::PH_YEAR: begin
          if (st.dcnt < 3'd4) begin
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.year = 14'({4'b0, st.year} * 18'd10 + {14'b0, dig});
              if (st.dcnt < 3'd2) begin
                st_next.yhi = acc10(st.yhi, dig);
              end else begin
                st_next.ylo = acc10(st.ylo, dig);
              end
              st_next.dcnt = st.dcnt + 3'd1;
            end
          end else if (char_code == iso_pkg::CH_MINUS) begin
            st_next.phase = iso_pkg::PH_MONTH;
            st_next.dcnt  = '0;
          end else begin
            st_next.err = 1'b1;
          end
        end
        iso_pkg::PH_MONTH: begin
          if (st.dcnt < 3'd2) begin
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.month = acc10(st.month, dig);
              st_next.dcnt  = st.dcnt + 3'd1;
            end
          end else if (char_code == iso_pkg::CH_MINUS && st.month >= 7'd1
                       && st.month <= 7'd12) begin
            st_next.phase = iso_pkg::PH_DAY;
            st_next.dcnt  = '0;
          end else begin
            st_next.err = 1'b1;
          end
        end
        iso_pkg::PH_DAY: begin
          if (!isd) begin
            st_next.err = 1'b1;
          end else begin
            st_next.day  = acc10(st.day, dig);
            st_next.dcnt = st.dcnt + 3'd1;
            if (st.dcnt == 3'd1) begin
              dok = (st_next.day >= 7'd1) && (st_next.day <= 7'd31);
              if (st_next.day >= 7'd29) begin
                if (st.month == 7'd2) begin
                  if (st_next.day > 7'd29 || !leap) begin
                    dok = 1'b0;
                  end
                end else if (st_next.day > 7'd30
                             && !iso_pkg::LONG_MONTH_MASK[st.month[3:0]]) begin
                  dok = 1'b0;
                end
              end
              if (!dok) begin
                st_next.err = 1'b1;
              end else begin
                st_next.phase = iso_pkg::PH_AFTER_DATE;
              end
            end
          end
        end
        iso_pkg::PH_AFTER_DATE: begin
          if (!(isspc || char_code == iso_pkg::CH_UPT)) begin
            st_next.phase = iso_pkg::PH_HOUR;
            st_next.dcnt  = '0;
            st_next.hour  = '0;
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.hour = {3'b0, dig};
              st_next.dcnt = 3'd1;
            end
          end
        end
        iso_pkg::PH_HOUR: begin
          if (st.dcnt < 3'd2) begin
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.hour = acc10(st.hour, dig);
              st_next.dcnt = st.dcnt + 3'd1;
            end
          end else if (char_code == iso_pkg::CH_COLON && st.hour <= 7'd24) begin
            st_next.phase = iso_pkg::PH_MIN;
            st_next.dcnt  = '0;
          end else begin
            st_next.err = 1'b1;
          end
        end
        iso_pkg::PH_MIN: begin
          if (!isd) begin
            st_next.err = 1'b1;
          end else begin
            st_next.minute = acc10(st.minute, dig);
            st_next.dcnt   = st.dcnt + 3'd1;
            if (st.dcnt == 3'd1) begin
              if (st_next.minute > 7'd59) begin
                st_next.err = 1'b1;
              end else begin
                st_next.phase = iso_pkg::PH_AFTER_MIN;
              end
            end
          end
        end
        iso_pkg::PH_AFTER_MIN: begin
          if (char_code == iso_pkg::CH_COLON) begin
            st_next.phase = iso_pkg::PH_SEC;
            st_next.dcnt  = '0;
          end else begin
            st_next = zone_start(st, char_code);
          end
        end
        iso_pkg::PH_SEC: begin
          if (!isd) begin
            st_next.err = 1'b1;
          end else begin
            st_next.second = acc10(st.second, dig);
            st_next.dcnt   = st.dcnt + 3'd1;
            if (st.dcnt == 3'd1) begin
              if (st_next.second > 7'd59) begin
                st_next.err = 1'b1;
              end else begin
                st_next.phase = iso_pkg::PH_AFTER_SEC;
              end
            end
          end
        end
        iso_pkg::PH_AFTER_SEC: begin
          if (char_code == iso_pkg::CH_DOT) begin
            st_next.phase = iso_pkg::PH_DOT;
          end else begin
            st_next = zone_start(st, char_code);
          end
        end
        iso_pkg::PH_DOT, iso_pkg::PH_FRAC: begin
          if (isd) begin
            // Only the first four digits count; the fourth rounds half up.
            if (st.fd < 3'd4) begin
              unique case (st.fd)
                3'd0:    st_next.fms = {6'b0, dig} * 10'd100;
                3'd1:    st_next.fms = st.fms + {6'b0, dig} * 10'd10;
                3'd2:    st_next.fms = st.fms + {6'b0, dig};
                default: st_next.fms = st.fms + {9'b0, (dig >= 4'd5)};
              endcase
              st_next.fd = st.fd + 3'd1;
            end
            st_next.phase = iso_pkg::PH_FRAC;
          end else if (st.phase == iso_pkg::PH_FRAC) begin
            st_next = zone_start(st, char_code);
          end else begin
            st_next.err = 1'b1;
          end
        end
        iso_pkg::PH_PRE_ZONE: begin
          st_next = zone_start(st, char_code);
        end
        iso_pkg::PH_ZHOUR: begin
          if (!isd) begin
            st_next.err = 1'b1;
          end else begin
            st_next.zhour = acc10(st.zhour, dig);
            st_next.dcnt  = st.dcnt + 3'd1;
            if (st.dcnt == 3'd1) begin
              if (st_next.zhour > 7'd14) begin
                st_next.err = 1'b1;
              end else begin
                st_next.phase = iso_pkg::PH_ZCOLON;
              end
            end
          end
        end
        iso_pkg::PH_ZCOLON: begin
          // The colon is optional: a digit here is the first zone-minute digit.
          st_next.dcnt  = '0;
          st_next.zmin  = '0;
          st_next.phase = iso_pkg::PH_ZMIN;
          if (char_code != iso_pkg::CH_COLON) begin
            if (!isd) begin
              st_next.err = 1'b1;
            end else begin
              st_next.zmin = {3'b0, dig};
              st_next.dcnt = 3'd1;
            end
          end
        end
        iso_pkg::PH_ZMIN: begin
          if (!isd) begin
            st_next.err = 1'b1;
          end else begin
            st_next.zmin = acc10(st.zmin, dig);
            st_next.dcnt = st.dcnt + 3'd1;
            if (st.dcnt == 3'd1) begin
              if (st_next.zmin > 7'd59) begin
                st_next.err = 1'b1;
              end else begin
                st_next.zgiven = 1'b1;
                st_next.phase  = iso_pkg::PH_TRAIL;
              end
            end
          end
        end
        iso_pkg::PH_TRAIL: begin
          if (!isspc) begin
            st_next.err = 1'b1;
          end
        end
        default: begin
          st_next.err = 1'b1;
        end
      endcase
    end
  end

  // The text is good only if it ends in a phase that closes a complete form.
  assign end_ok = !st_next.err && (st_next.phase == iso_pkg::PH_AFTER_DATE
                  || st_next.phase == iso_pkg::PH_AFTER_MIN
                  || st_next.phase == iso_pkg::PH_AFTER_SEC
                  || st_next.phase == iso_pkg::PH_FRAC
                  || st_next.phase == iso_pkg::PH_PRE_ZONE
                  || st_next.phase == iso_pkg::PH_TRAIL);

  // Record for the arithmetic, built from the state after the last byte.
  always_comb begin
    rec.ok          = end_ok;
    rec.year_neg    = st_next.yneg;
    rec.year        = st_next.year;
    rec.month       = st_next.month[3:0];
    rec.day         = st_next.day[4:0];
    rec.hour        = st_next.hour[4:0];
    rec.minute      = st_next.minute[5:0];
    rec.second      = st_next.second[5:0];
    rec.frac_ms     = st_next.fms;
    rec.zone_given  = st_next.zgiven;
    rec.zone_neg    = st_next.zneg;
    rec.zone_hour   = st_next.zhour[3:0];
    rec.zone_minute = st_next.zmin[5:0];
  end

  assign rec_push = take && last_char;

  // Parse state register; the last byte returns it to the start of text,
  // whose phase code is all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      if (last_char) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

endmodule

>>> rtl/core/iso_back.sv
// Arithmetic back end: turns a parsed record into epoch milliseconds.
// Depends on iso_pkg for the record and result types and the constants.
module iso_back #(
  parameter int OUT_DEPTH = iso_pkg::OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rec_valid,
  input  iso_pkg::rec_t                      rec,
  output logic                               rec_pop,
  input  logic signed [11:0]                 local_offset_minutes,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               res_push,
  output iso_pkg::res_t                      res
);

  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam int SW = $clog2(OUT_DEPTH + iso_pkg::PIPE_STAGES + 1);

  logic [iso_pkg::PIPE_STAGES-1:0] vld;
  logic [SW-1:0]                   pending;

  // Stage 1 registers.
  logic               s1_ok;
  logic signed [14:0] s1_ya;
  logic [3:0]         s1_ma;
  logic [4:0]         s1_day;
  logic signed [13:0] s1_hm;
  logic [15:0]        s1_sms;
  // Stage 2 registers.
  logic               s2_ok;
  logic signed [7:0]  s2_a;
  logic signed [25:0] s2_t;
  logic [8:0]         s2_x2;
  logic [4:0]         s2_day;
  logic signed [29:0] s2_tod;
  // Stage 3 registers.
  logic               s3_ok;
  logic signed [23:0] s3_x1;
  logic signed [9:0]  s3_b;
  logic [8:0]         s3_x2;
  logic [4:0]         s3_day;
  logic signed [29:0] s3_tod;
  // Stage 4 registers.
  logic               s4_ok;
  logic signed [24:0] s4_days;
  logic signed [29:0] s4_tod;
  // Stage 5 registers.
  logic               s5_ok;
  logic signed [51:0] s5_prod;
  logic signed [29:0] s5_tod;

  // Stage 1 logic.
  logic               c1_mle2;
  logic signed [14:0] c1_ys;
  logic [9:0]         c1_zmag;
  logic signed [11:0] c1_tz;
  logic [10:0]        c1_hmin;
  // Stage 2 logic.
  logic [13:0]        c2_yabs;
  logic [26:0]        c2_qprod;
  logic [6:0]         c2_aq;
  logic signed [15:0] c2_yy;
  // Stage 3 logic.
  logic signed [25:0] c3_tq;
  logic signed [7:0]  c3_aq;
  // Result logic.
  logic signed [51:0] c6_sum;

  // Take a record only when the output queue has room for every item in flight.
  assign pending = SW'(out_count) + SW'($countones(vld));
  assign rec_pop = rec_valid && (pending < SW'(OUT_DEPTH));

  // Stage 1: adjust year and month, fold the clock time and zone into minutes and the seconds into ms.
  always_comb begin
    c1_mle2 = (rec.month <= 4'd2);
    c1_ys   = rec.year_neg ? -$signed({1'b0, rec.year}) : $signed({1'b0, rec.year});
    c1_zmag = {6'b0, rec.zone_hour} * 10'd60 + {4'b0, rec.zone_minute};
    if (rec.zone_given) begin
      c1_tz = rec.zone_neg ? -$signed({2'b0, c1_zmag}) : $signed({2'b0, c1_zmag});
    end else begin
      c1_tz = local_offset_minutes;
    end
    c1_hmin = {6'b0, rec.hour} * 11'd60 + {5'b0, rec.minute};
  end

  always_ff @(posedge clk) begin
    s1_ok  <= rec.ok;
    s1_ya  <= c1_mle2 ? c1_ys - 15'sd1 : c1_ys;
    s1_ma  <= c1_mle2 ? rec.month + 4'd12 : rec.month;
    s1_day <= rec.day;
    s1_hm  <= $signed({3'b0, c1_hmin}) - $signed({{2{c1_tz[11]}}, c1_tz});
    s1_sms <= {10'b0, rec.second} * 16'd1000 + {6'b0, rec.frac_ms};
  end

  // Stage 2: century by reciprocal multiply, year term product, month term, time of day.
  always_comb begin
    c2_yabs  = s1_ya[14] ? 14'(-s1_ya) : 14'(s1_ya);
    c2_qprod = {13'b0, c2_yabs} * 27'd5243;
    c2_aq    = c2_qprod[25:19];
    c2_yy    = $signed({s1_ya[14], s1_ya}) + 16'sd4716;
  end

  always_ff @(posedge clk) begin
    s2_ok  <= s1_ok;
    s2_a   <= s1_ya[14] ? -$signed({1'b0, c2_aq}) : $signed({1'b0, c2_aq});
    s2_t   <= $signed({{10{c2_yy[15]}}, c2_yy}) * 26'sd1461;
    s2_x2  <= iso_pkg::month_days(s1_ma);
    s2_day <= s1_day;
    s2_tod <= $signed({{16{s1_hm[13]}}, s1_hm}) * 30'sd60000 + $signed({14'b0, s1_sms});
  end

  // Stage 3: quarter divisions rounded toward zero, Gregorian correction.
  always_comb begin
    c3_tq = s2_t[25] ? s2_t + 26'sd3 : s2_t;
    c3_aq = s2_a[7] ? s2_a + 8'sd3 : s2_a;
  end

  always_ff @(posedge clk) begin
    s3_ok  <= s2_ok;
    s3_x1  <= c3_tq[25:2];
    s3_b   <= 10'sd2 - $signed({{2{s2_a[7]}}, s2_a})
              + $signed({{4{c3_aq[7]}}, c3_aq[7:2]});
    s3_x2  <= s2_x2;
    s3_day <= s2_day;
    s3_tod <= s2_tod;
  end

  // Stage 4: day count.
  always_ff @(posedge clk) begin
    s4_ok   <= s3_ok;
    s4_days <= $signed({s3_x1[23], s3_x1}) + $signed({16'b0, s3_x2})
               + $signed({20'b0, s3_day}) + $signed({{15{s3_b[9]}}, s3_b})
               - 25'sd1524;
    s4_tod  <= s3_tod;
  end

  // Stage 5: days to milliseconds.
  always_ff @(posedge clk) begin
    s5_ok   <= s4_ok;
    s5_prod <= $signed({{27{s4_days[24]}}, s4_days}) * iso_pkg::MS_PER_DAY;
    s5_tod  <= s4_tod;
  end

  // Final sum and epoch shift; a failed parse reports zero.
  assign c6_sum    = s5_prod + $signed({{22{s5_tod[29]}}, s5_tod}) - iso_pkg::EPOCH_BIAS_MS;
  assign res.valid = s5_ok;
  assign res.epoch = s5_ok ? c6_sum[49:0] : '0;
  assign res_push  = vld[iso_pkg::PIPE_STAGES-1];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[iso_pkg::PIPE_STAGES-2:0], rec_pop};
    end
  end

`ifndef SYNTHESIS
  a_credit: assert property (@(posedge clk) disable iff (rst) pending <= SW'(OUT_DEPTH))
    else $error("more items in flight than output space");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) rec_pop |-> rec_valid)
    else $error("record taken from an empty queue");
`endif

endmodule
